FILE: hw/rtl/lkvc_pkg.sv
package lkvc_pkg;

    localparam int KEY_W   = 32;
    localparam int VALUE_W = 32;
    localparam int CFG_W   = 5;

    localparam logic [CFG_W-1:0]   CAPACITY_RESET = 5'd16;
    localparam logic [VALUE_W-1:0] DATA_MISS      = '1;
    localparam logic [VALUE_W-1:0] DATA_PUT       = '0;

    typedef enum logic {
        CMD_GET = 1'b0,
        CMD_PUT = 1'b1
    } t_cmd;

    typedef struct packed {
        t_cmd                       command;
        logic signed [KEY_W-1:0]    key;
        logic signed [VALUE_W-1:0]  value;
    } t_req;

    typedef struct packed {
        logic                       found;
        logic signed [VALUE_W-1:0]  data;
    } t_rsp;

endpackage

FILE: hw/rtl/lru_key_value_cache_core.sv
// Fully associative key/value cache with least-recently-used replacement.
// Request channel (i_req_valid / o_req_ready, payload i_req) carries a get or
// a put; the response channel (o_rsp_valid / i_rsp_ready, payload o_rsp)
// returns exactly one response per request, in order: found flag and data.
// A request is held in the input register; the lookup and table update run
// combinationally from that register and the result is captured in the
// response register, which drives o_rsp_valid and o_rsp. Throughput is one
// request per cycle while i_rsp_ready is high, set by the parallel key
// compare and rank update over all table slots.
// The capacity register is written through i_cfg_we / i_cfg_data; the user must
// write it only while no request is in flight, which the core does not enforce.
// It resets to 16. Reset empties the table (all valid marks cleared, count zero)
// and drops any request or response in flight.
// When i_rsp_ready is low the response register holds and the request in
// the input register waits; o_req_ready falls once both are occupied.
module lru_key_value_cache_core #(
    parameter int CAPACITY = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_req_valid,
    output logic                        o_req_ready,
    input  lkvc_pkg::t_req              i_req,
    output logic                        o_rsp_valid,
    input  logic                        i_rsp_ready,
    output lkvc_pkg::t_rsp              o_rsp,
    input  logic                        i_cfg_we,
    input  logic [lkvc_pkg::CFG_W-1:0]  i_cfg_data
);

    logic                        r_req_valid;
    lkvc_pkg::t_req              r_req;
    logic                        r_rsp_valid;
    lkvc_pkg::t_rsp              r_rsp;
    logic [lkvc_pkg::CFG_W-1:0]  r_capacity;
    lkvc_pkg::t_rsp              w_rsp;
    logic                        w_fire;

    assign w_fire      = r_req_valid && (!r_rsp_valid || i_rsp_ready);
    assign o_req_ready = !r_req_valid || w_fire;
    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= lkvc_pkg::CAPACITY_RESET;
        end else if (i_cfg_we) begin
            r_capacity <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_valid <= 1'b0;
            r_rsp_valid <= 1'b0;
        end else begin
            if (o_req_ready) begin
                r_req_valid <= i_req_valid;
            end
            if (w_fire) begin
                r_rsp_valid <= 1'b1;
            end else if (i_rsp_ready) begin
                r_rsp_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_req_ready && i_req_valid) begin
            r_req <= i_req;
        end
        if (w_fire) begin
            r_rsp <= w_rsp;
        end
    end

    lkvc_store #(
        .CAPACITY (CAPACITY)
    ) u_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fire     (w_fire),
        .i_req      (r_req),
        .i_capacity (r_capacity),
        .o_rsp      (w_rsp)
    );

    a_hold_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_req_valid && !w_fire |=> r_req_valid && $stable(r_req))
        else $error("pending request lost");

    a_fire_gives_rsp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire |=> r_rsp_valid)
        else $error("processed request produced no response");

    a_hold_rsp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rsp_valid && !i_rsp_ready |=> r_rsp_valid && $stable(r_rsp))
        else $error("stalled response changed");

endmodule

FILE: hw/rtl/lkvc_store.sv
module lkvc_store #(
    parameter int CAPACITY = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_fire,
    input  lkvc_pkg::t_req                 i_req,
    input  logic [lkvc_pkg::CFG_W-1:0]     i_capacity,
    output lkvc_pkg::t_rsp                 o_rsp
);

    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    logic [CAPACITY-1:0]                 r_valid;
    logic [CAPACITY-1:0]                 n_valid;
    logic [lkvc_pkg::KEY_W-1:0]          r_key   [CAPACITY];
    logic [lkvc_pkg::VALUE_W-1:0]        r_value [CAPACITY];
    logic [IW-1:0]                       r_rank  [CAPACITY];
    logic [IW-1:0]                       n_rank  [CAPACITY];
    logic [CW-1:0]                       r_count;
    logic [CW-1:0]                       n_count;

    logic [CAPACITY-1:0] w_hit;
    logic [CAPACITY-1:0] w_lru;
    logic [IW-1:0]       w_hit_idx;
    logic [IW-1:0]       w_free_idx;
    logic [IW-1:0]       w_lru_idx;
    logic [IW-1:0]       w_tgt;
    logic [IW-1:0]       w_tgt_rank;
    logic [CW-1:0]       w_last;
    logic [CW-1:0]       w_eff_cap;
    logic                w_found;
    logic                w_put;
    logic                w_room;
    logic                w_insert;
    logic                w_update;

    assign w_put   = (i_req.command == lkvc_pkg::CMD_PUT);
    assign w_last  = CW'(r_count - CW'(1));
    assign w_found = |w_hit;
    assign w_room  = (r_count < w_eff_cap);

    // a zero capacity acts as one; anything above the table size saturates
    always_comb begin
        if (i_capacity == '0) begin
            w_eff_cap = CW'(1);
        end else if (int'(i_capacity) > CAPACITY) begin
            w_eff_cap = CW'(CAPACITY);
        end else begin
            w_eff_cap = CW'(i_capacity);
        end
    end

    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            w_hit[i] = r_valid[i] && (r_key[i] == i_req.key);
            w_lru[i] = r_valid[i] && (r_rank[i] == IW'(w_last));
        end
    end

    // lowest matching slot wins
    always_comb begin
        w_hit_idx  = '0;
        w_free_idx = '0;
        w_lru_idx  = '0;
        for (int i = CAPACITY - 1; i >= 0; i--) begin
            if (w_hit[i]) begin
                w_hit_idx = IW'(i);
            end
            if (!r_valid[i]) begin
                w_free_idx = IW'(i);
            end
            if (w_lru[i]) begin
                w_lru_idx = IW'(i);
            end
        end
    end

    always_comb begin
        w_insert = 1'b0;
        w_update = 1'b1;
        if (w_found) begin
            w_tgt = w_hit_idx;
        end else if (w_put && w_room) begin
            w_tgt    = w_free_idx;
            w_insert = 1'b1;
        end else begin
            w_tgt    = w_lru_idx;
            w_update = w_put;
        end
        w_tgt_rank = r_rank[w_tgt];
    end

    always_comb begin
        o_rsp.found = w_found;
        if (w_put) begin
            o_rsp.data = lkvc_pkg::DATA_PUT;
        end else if (w_found) begin
            o_rsp.data = r_value[w_hit_idx];
        end else begin
            o_rsp.data = lkvc_pkg::DATA_MISS;
        end
    end

    // age every valid entry more recent than the target; an insert ages all of them
    always_comb begin
        n_valid = r_valid;
        n_count = r_count;
        for (int i = 0; i < CAPACITY; i++) begin
            n_rank[i] = r_rank[i];
            if (IW'(i) == w_tgt) begin
                n_rank[i] = '0;
            end else if (r_valid[i] && (w_insert || (r_rank[i] < w_tgt_rank))) begin
                n_rank[i] = IW'(r_rank[i] + IW'(1));
            end
        end
        if (w_insert) begin
            n_valid[w_tgt] = 1'b1;
            n_count        = CW'(r_count + CW'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_count <= '0;
        end else if (i_fire && w_update) begin
            r_valid <= n_valid;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire && w_update) begin
            r_rank <= n_rank;
        end
        if (i_fire && w_put) begin
            r_key[w_tgt]   <= i_req.key;
            r_value[w_tgt] <= i_req.value;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_count) <= CAPACITY)
        else $error("entry count above table size");

    a_count_matches_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_valid) == int'(r_count))
        else $error("entry count differs from valid marks");

    a_unique_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_hit))
        else $error("key stored in more than one slot");

    a_put_leaves_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && w_put |=> r_valid != '0)
        else $error("put left the table empty");

    a_single_lru: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count != '0 |-> $onehot(w_lru))
        else $error("least recent entry not unique");

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

    localparam int SLOTS       = 16;
    localparam int POOL_SIZE   = 24;
    localparam int PHASE_ITEMS = 135;
    localparam int HOLD_AT     = 500;
    localparam int HOLD_CYCLES = 400;
    localparam int CYCLE_LIMIT = 1000000;

    logic                       i_clk       = 1'b0;
    logic                       i_rst_n     = 1'b0;
    logic                       i_req_valid = 1'b0;
    logic                       o_req_ready;
    lkvc_pkg::t_req             i_req       = '0;
    logic                       o_rsp_valid;
    logic                       i_rsp_ready = 1'b0;
    lkvc_pkg::t_rsp             o_rsp;
    logic                       i_cfg_we    = 1'b0;
    logic [lkvc_pkg::CFG_W-1:0] i_cfg_data  = '0;

    lru_key_value_cache_core #(
        .CAPACITY (SLOTS)
    ) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .i_req       (i_req),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_ready (i_rsp_ready),
        .o_rsp       (o_rsp),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Cache mirror: slot table, recency ranks and the capacity register.
    bit                           slot_live [SLOTS];
    logic [lkvc_pkg::KEY_W-1:0]   slot_key  [SLOTS];
    logic [lkvc_pkg::VALUE_W-1:0] slot_val  [SLOTS];
    int unsigned                  slot_rank [SLOTS];
    int unsigned                  live_count;
    logic [lkvc_pkg::CFG_W-1:0]   cap_reg;

    lkvc_pkg::t_req             pending_reqs[$];
    lkvc_pkg::t_rsp             lookup_results[$];
    logic [lkvc_pkg::KEY_W-1:0] key_pool[POOL_SIZE];

    bit idle_on         = 1'b0;
    int req_gap_left    = 0;
    int rsp_stall_left  = 0;
    int hold_left       = 0;
    bit hold_armed      = 1'b1;
    int reqs_accepted   = 0;
    int rsps_seen       = 0;
    int mismatch_count  = 0;
    int cycle_count     = 0;

    function automatic void cache_clear();
        for (int i = 0; i < SLOTS; i++) begin
            slot_live[i] = 1'b0;
            slot_key[i]  = '0;
            slot_val[i]  = '0;
            slot_rank[i] = 0;
        end
        live_count = 0;
        cap_reg    = lkvc_pkg::CAPACITY_RESET;
    endfunction

    function automatic int unsigned cap_limit(logic [lkvc_pkg::CFG_W-1:0] c);
        if (c == 0)
            return 1;
        if (c > SLOTS)
            return SLOTS;
        return c;
    endfunction

    // Entries that were more recent than s age by one; s becomes rank 0.
    function automatic void make_newest(int s);
        int unsigned r;
        r = slot_rank[s];
        for (int i = 0; i < SLOTS; i++)
            if (slot_live[i] && i != s && slot_rank[i] < r)
                slot_rank[i]++;
        slot_rank[s] = 0;
    endfunction

    function automatic lkvc_pkg::t_rsp cache_access(lkvc_pkg::t_req rq);
        lkvc_pkg::t_rsp r;
        int             hit;
        int             slot;
        int             victim;
        int unsigned    worst;
        hit = -1;
        for (int i = 0; i < SLOTS; i++)
            if (hit < 0 && slot_live[i] && slot_key[i] == rq.key)
                hit = i;
        r.found = (hit >= 0);
        if (rq.command == lkvc_pkg::CMD_GET) begin
            if (hit >= 0) begin
                make_newest(hit);
                r.data = slot_val[hit];
            end else begin
                r.data = lkvc_pkg::DATA_MISS;
            end
            return r;
        end
        r.data = lkvc_pkg::DATA_PUT;
        if (hit >= 0) begin
            slot_val[hit] = rq.value;
            make_newest(hit);
            return r;
        end
        slot = -1;
        if (live_count < cap_limit(cap_reg))
            for (int i = 0; i < SLOTS; i++)
                if (slot < 0 && !slot_live[i])
                    slot = i;
        if (slot >= 0) begin
            for (int i = 0; i < SLOTS; i++)
                if (slot_live[i])
                    slot_rank[i]++;
            slot_live[slot] = 1'b1;
            slot_key[slot]  = rq.key;
            slot_val[slot]  = rq.value;
            slot_rank[slot] = 0;
            live_count++;
            return r;
        end
        // Table at capacity: overwrite the least recent entry in place.
        victim = -1;
        worst  = 0;
        for (int i = 0; i < SLOTS; i++)
            if (slot_live[i] && (victim < 0 || slot_rank[i] > worst)) begin
                victim = i;
                worst  = slot_rank[i];
            end
        if (victim >= 0) begin
            slot_key[victim] = rq.key;
            slot_val[victim] = rq.value;
            make_newest(victim);
        end
        return r;
    endfunction

    // Mostly no gap, some short ones, a few long ones.
    function automatic int pick_gap();
        int r;
        if (!idle_on)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic lkvc_pkg::t_req random_req(int span);
        lkvc_pkg::t_req rq;
        rq.command = ($urandom_range(0, 1) == 1) ? lkvc_pkg::CMD_PUT : lkvc_pkg::CMD_GET;
        if ($urandom_range(0, 9) == 0)
            rq.key = $urandom;
        else
            rq.key = key_pool[$urandom_range(0, span - 1)];
        rq.value = $urandom;
        return rq;
    endfunction

    task automatic queue_req(lkvc_pkg::t_cmd cmd, logic [lkvc_pkg::KEY_W-1:0] k,
                             logic [lkvc_pkg::VALUE_W-1:0] v);
        lkvc_pkg::t_req rq;
        rq.command = cmd;
        rq.key     = k;
        rq.value   = v;
        pending_reqs.push_back(rq);
    endtask

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        mismatch_count++;
        $display("mismatch at response %0d: %s got %h want %h", rsps_seen, what, got, want);
    endtask

    // Block until every request has been sent and answered, then let it settle.
    task automatic wait_drained();
        do
            @(negedge i_clk);
        while (pending_reqs.size() != 0 || i_req_valid || lookup_results.size() != 0);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_capacity(logic [lkvc_pkg::CFG_W-1:0] c);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= c;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        cap_reg = c;
    endtask

    always @(posedge i_clk) begin : req_driver
        lkvc_pkg::t_req nxt_req;
        logic           nxt_valid;
        if (!i_rst_n) begin
            i_req_valid  <= 1'b0;
            req_gap_left = 0;
        end else begin
            nxt_valid = i_req_valid;
            nxt_req   = i_req;
            if (i_req_valid && o_req_ready) begin
                lookup_results.push_back(cache_access(i_req));
                reqs_accepted <= reqs_accepted + 1;
                nxt_valid = 1'b0;
            end
            if (!nxt_valid) begin
                if (req_gap_left > 0) begin
                    req_gap_left--;
                end else if (pending_reqs.size() > 0) begin
                    nxt_req      = pending_reqs.pop_front();
                    nxt_valid    = 1'b1;
                    req_gap_left = pick_gap();
                end
            end
            i_req_valid <= nxt_valid;
            i_req       <= nxt_req;
        end
    end

    always @(posedge i_clk) begin : rsp_monitor
        lkvc_pkg::t_rsp want;
        if (!i_rst_n) begin
            i_rsp_ready    <= 1'b0;
            rsp_stall_left = 0;
        end else begin
            if (o_rsp_valid && i_rsp_ready) begin
                rsps_seen++;
                if (lookup_results.size() == 0) begin
                    report_mismatch("unexpected response, data", o_rsp.data, '0);
                end else begin
                    want = lookup_results.pop_front();
                    if (o_rsp.found !== want.found)
                        report_mismatch("found", 32'(o_rsp.found), 32'(want.found));
                    if (o_rsp.data !== want.data)
                        report_mismatch("data", o_rsp.data, want.data);
                end
            end
            if (rsp_stall_left > 0)
                rsp_stall_left--;
            else
                rsp_stall_left = pick_gap();
            i_rsp_ready <= (rsp_stall_left == 0) && (hold_left == 0);
        end
    end

    // One long back-pressure stretch while the sender keeps offering requests.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left  <= 0;
            hold_armed <= 1'b1;
        end else if (hold_armed && reqs_accepted >= HOLD_AT) begin
            hold_left  <= HOLD_CYCLES;
            hold_armed <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("[lru_key_value_cache_core] ERROR");
            $finish;
        end
    end

    initial begin : stimulus
        logic [lkvc_pkg::CFG_W-1:0] caps[10];
        int                         span;
        cache_clear();
        key_pool[0] = 32'h8000_0000;
        key_pool[1] = 32'h7fff_ffff;
        key_pool[2] = 32'h0000_0000;
        key_pool[3] = 32'hffff_ffff;
        for (int i = 4; i < POOL_SIZE; i++)
            key_pool[i] = $urandom;
        caps = '{5'd31, 5'd16, 5'd0, 5'd1, 5'd17, 5'd7, 5'd3, 5'd16, 5'd0, 5'd2};
        caps[8] = $urandom_range(0, 31);

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset capacity: misses, inserts at the key and value extremes, updates.
        idle_on = 1'b1;
        queue_req(lkvc_pkg::CMD_GET, 32'h0000_0000, 32'h0000_0000);
        queue_req(lkvc_pkg::CMD_PUT, 32'h8000_0000, 32'h7fff_ffff);
        queue_req(lkvc_pkg::CMD_PUT, 32'h7fff_ffff, 32'h8000_0000);
        queue_req(lkvc_pkg::CMD_GET, 32'h8000_0000, 32'hffff_ffff);
        queue_req(lkvc_pkg::CMD_GET, 32'h7fff_ffff, 32'h0000_0000);
        queue_req(lkvc_pkg::CMD_PUT, 32'h8000_0000, 32'h0000_0000);
        queue_req(lkvc_pkg::CMD_GET, 32'h8000_0000, 32'h0000_0000);
        queue_req(lkvc_pkg::CMD_GET, 32'hffff_ffff, 32'h0000_0000);
        queue_req(lkvc_pkg::CMD_PUT, 32'hffff_ffff, 32'hffff_ffff);
        queue_req(lkvc_pkg::CMD_GET, 32'hffff_ffff, 32'h0000_0000);
        queue_req(lkvc_pkg::CMD_PUT, 32'h0000_0000, 32'h0000_0001);
        queue_req(lkvc_pkg::CMD_GET, 32'h0000_0000, 32'h5a5a_5a5a);
        wait_drained();

        // Capacity below the entry count: puts of new keys replace the oldest.
        write_capacity(5'd2);
        queue_req(lkvc_pkg::CMD_PUT, 32'h0000_0005, 32'h1234_5678);
        queue_req(lkvc_pkg::CMD_GET, 32'h7fff_ffff, 32'h0000_0000);
        queue_req(lkvc_pkg::CMD_GET, 32'h8000_0000, 32'h0000_0000);
        queue_req(lkvc_pkg::CMD_PUT, 32'h0000_0006, 32'hcafe_f00d);
        queue_req(lkvc_pkg::CMD_GET, 32'hffff_ffff, 32'h0000_0000);
        queue_req(lkvc_pkg::CMD_GET, 32'h0000_0000, 32'h0000_0000);
        queue_req(lkvc_pkg::CMD_GET, 32'h0000_0005, 32'h0000_0000);
        queue_req(lkvc_pkg::CMD_GET, 32'h0000_0006, 32'h0000_0000);
        queue_req(lkvc_pkg::CMD_PUT, 32'h0000_0005, 32'h8765_4321);
        queue_req(lkvc_pkg::CMD_GET, 32'h0000_0005, 32'h0000_0000);
        wait_drained();

        for (int ph = 0; ph < 10; ph++) begin
            write_capacity(caps[ph]);
            idle_on = (ph % 3 != 1);
            // Refresh part of the key pool so new keys keep arriving.
            for (int i = 0; i < 3; i++)
                key_pool[$urandom_range(4, POOL_SIZE - 1)] = $urandom;
            span = cap_limit(caps[ph]) + 4;
            if (span < 6)
                span = 6;
            if (span > POOL_SIZE)
                span = POOL_SIZE;
            for (int n = 0; n < PHASE_ITEMS; n++)
                pending_reqs.push_back(random_req(span));
            wait_drained();
        end

        repeat (8) @(negedge i_clk);
        if (mismatch_count == 0 && lookup_results.size() == 0)
            $display("[lru_key_value_cache_core] OK");
        else
            $display("[lru_key_value_cache_core] ERROR");
        $finish;
    end

endmodule
